// ===== src/aewq_pkg.sv =====
// Package for the event waiter queue: transaction structs, command and
// outcome codes, register indexes and the control struct of the queue cells.
// No dependencies.
`default_nettype none

package aewq_pkg;

  localparam int unsigned IdW    = 8;
  localparam int unsigned OutCntW = 5;

  typedef enum logic [1:0] {
    CMD_WAIT   = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_SET    = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OC_NONE      = 2'd0,
    OC_SUCCESS   = 2'd1,
    OC_CANCELLED = 2'd2,
    OC_FULL      = 2'd3
  } outcome_e;

  localparam logic REG_MANUAL_MODE = 1'b0;
  localparam logic REG_INIT_SIG    = 1'b1;

  typedef struct packed {
    logic [1:0]     command;
    logic [IdW-1:0] waiter_id;
  } in_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic [IdW-1:0]     completed_id;
    logic               is_signaled;
    logic [OutCntW-1:0] waiter_count;
    logic               last_result;
  } out_t;

  // Per-cycle orders broadcast to every queue cell
  typedef struct packed {
    logic           capture;
    logic           push;
    logic           pop;
    logic           cancel;
    logic [IdW-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/async_event_waiter_queue.sv =====
// Top level of the event waiter queue: command sequencer, signaled flag,
// output register and a row of aewq_cell slots. Depends on aewq_pkg.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------
//  in       | in_valid_i / in_ready_o | in_data_i   (in_t)
//  out      | out_valid_o/ out_ready_i| out_data_o  (out_t)
//  cfg      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A command is first accepted (cells register their id compare), then
// executed into the output register. A manual-mode set releases its waiters
// with one head pop per cycle through the cells, while the output register is free.
// Execution waits while the output register holds an untaken result.
// Reset empties the queue and clears the flag and the mode register.
`default_nettype none

module async_event_waiter_queue
  import aewq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o,
  input  wire logic cfg_we_i,
  input  wire logic cfg_idx_i,
  input  wire logic cfg_data_i
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_REL  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [1:0]      cmd_q;
  logic [IdW-1:0]  id_q;
  logic            manual_q;
  logic            flag_q, flag_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;
  logic            out_free;
  cell_ctl_t       ctl;

  logic [QUEUE_DEPTH:0] occ_w;
  logic [QUEUE_DEPTH:0] found_w;
  logic [IdW-1:0]       id_w [QUEUE_DEPTH+1];
  logic                 found_any;
  logic                 q_full, q_empty;

  assign occ_w[QUEUE_DEPTH] = 1'b0;
  assign id_w[QUEUE_DEPTH]  = '0;
  assign found_w[0]         = 1'b0;
  assign found_any          = found_w[QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic prv_occ;
    if (i == 0) begin : g_head
      assign prv_occ = 1'b1;
    end else begin : g_body
      assign prv_occ = occ_w[i-1];
    end
    aewq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .prv_occ_i (prv_occ),
      .nxt_occ_i (occ_w[i+1]),
      .nxt_id_i  (id_w[i+1]),
      .found_i   (found_w[i]),
      .found_o   (found_w[i+1]),
      .occ_o     (occ_w[i]),
      .id_o      (id_w[i])
    );
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign q_full     = (count_q == CntW'(QUEUE_DEPTH));
  assign q_empty    = (count_q == '0);

  function automatic logic [OutCntW-1:0] trim_cnt(input logic [CntW-1:0] c);
    logic [CntW+OutCntW-1:0] wide;
    wide = {{OutCntW{1'b0}}, c};
    return wide[OutCntW-1:0];
  endfunction

  always_comb begin
    state_d     = state_q;
    flag_d      = flag_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctl         = '0;
    ctl.key     = (state_q == S_IDLE) ? in_data_i.waiter_id : id_q;
    ctl.capture = (state_q == S_IDLE) && in_valid_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_d.outcome      = OC_NONE;
          out_d.completed_id = '0;
          out_d.last_result  = 1'b1;
          state_d            = S_IDLE;
          case (cmd_q)
            CMD_WAIT: begin
              if (flag_q) begin
                flag_d             = manual_q;
                out_d.outcome      = OC_SUCCESS;
                out_d.completed_id = id_q;
              end else if (q_full) begin
                out_d.outcome      = OC_FULL;
                out_d.completed_id = id_q;
              end else begin
                ctl.push = 1'b1;
                count_d  = count_q + CntW'(1);
              end
            end
            CMD_CANCEL: begin
              ctl.cancel = 1'b1;
              if (found_any) begin
                count_d            = count_q - CntW'(1);
                out_d.outcome      = OC_CANCELLED;
                out_d.completed_id = id_q;
              end
            end
            CMD_SET: begin
              if (!flag_q) begin
                if (q_empty) begin
                  flag_d = 1'b1;
                end else begin
                  ctl.pop            = 1'b1;
                  out_d.outcome      = OC_SUCCESS;
                  out_d.completed_id = id_w[0];
                  if (manual_q) begin
                    // release the whole queue, head first
                    flag_d            = 1'b1;
                    count_d           = count_q - CntW'(1);
                    out_d.last_result = (count_q == CntW'(1));
                    if (count_q != CntW'(1)) begin
                      state_d = S_REL;
                    end
                  end else begin
                    count_d = count_q - CntW'(1);
                  end
                end
              end
            end
            default: begin
              flag_d = 1'b0;
            end
          endcase
          // manual release reports the empty queue on every result
          out_d.is_signaled  = flag_d;
          out_d.waiter_count = (manual_q && cmd_q == CMD_SET && !flag_q)
                               ? '0 : trim_cnt(count_d);
          out_valid_d        = 1'b1;
        end
      end
      S_REL: begin
        if (out_free) begin
          ctl.pop            = 1'b1;
          count_d            = count_q - CntW'(1);
          out_d.outcome      = OC_SUCCESS;
          out_d.completed_id = id_w[0];
          out_d.is_signaled  = flag_q;
          out_d.waiter_count = '0;
          out_d.last_result  = (count_q == CntW'(1));
          out_valid_d        = 1'b1;
          if (count_q == CntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      manual_q    <= 1'b0;
      flag_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      // a write of the initial value loads the flag at once
      if (cfg_we_i && cfg_idx_i == REG_INIT_SIG) begin
        flag_q <= cfg_data_i;
      end else begin
        flag_q <= flag_d;
      end
      if (cfg_we_i && cfg_idx_i == REG_MANUAL_MODE) begin
        manual_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (ctl.capture) begin
      cmd_q <= in_data_i.command;
      id_q  <= in_data_i.waiter_id;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== src/aewq_cell.sv =====
// One slot of the waiter queue: holds an id and an occupancy bit, takes its
// upper neighbour's contents on a shift. Depends on aewq_pkg.
`default_nettype none

module aewq_cell
  import aewq_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cell_ctl_t      ctl_i,
  input  wire logic           prv_occ_i,
  input  wire logic           nxt_occ_i,
  input  wire logic [IdW-1:0] nxt_id_i,
  input  wire logic           found_i,
  output logic                found_o,
  output logic                occ_o,
  output logic [IdW-1:0]      id_o
);

  logic           occ_q, occ_d;
  logic [IdW-1:0] id_q, id_d;
  logic           match_q;
  logic           shift;

  // found_o: this cell or an older one holds the oldest match
  assign found_o = found_i | match_q;
  assign shift   = ctl_i.pop | (ctl_i.cancel & found_o);

  always_comb begin
    occ_d = occ_q;
    id_d  = id_q;
    if (shift) begin
      occ_d = nxt_occ_i;
      id_d  = nxt_id_i;
    end else if (ctl_i.push && !occ_q && prv_occ_i) begin
      occ_d = 1'b1;
      id_d  = ctl_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      match_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (ctl_i.capture) begin
        match_q <= occ_q && (id_q == ctl_i.key);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign occ_o = occ_q;
  assign id_o  = id_q;

endmodule

`default_nettype wire
